@@ rtl/scalar_kalman_filter_assert.svh @@
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define SKF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("skf assertion failed (same cycle)");
// Next-cycle implication, disabled while in reset.
`define SKF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("skf assertion failed (next cycle)");
`else
`define SKF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SKF_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/skf_pkg.sv @@
// Shared constants and types of the scalar Kalman filter.
package skf_pkg;

    // Gain format: Q0.16, one extra bit so that one itself fits
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam int GAIN_ONE  = 1 << GAIN_BITS;

    // Estimate, covariance and derived widths
    localparam int DATA_W = 32;
    localparam int DIFF_W = DATA_W + 1;
    localparam int DEN_W  = DATA_W + 1;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd1310720;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd13107200;

    // One quotient bit travelling from the divider to the accumulators
    typedef struct packed {
        logic valid;
        logic qbit;
        logic last;
    } skf_qbit_t;

endpackage

@@ rtl/skf_div.sv @@
// Bit-serial restoring divider producing the gain one quotient bit per cycle, MSB first.
`include "scalar_kalman_filter_assert.svh"
module skf_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [skf_pkg::DATA_W-1:0]  num,
    input  logic [skf_pkg::DEN_W-1:0]   den,
    output skf_pkg::skf_qbit_t          q_out
);

    localparam int STEPS = skf_pkg::GAIN_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = skf_pkg::DEN_W + 1;

    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [skf_pkg::DEN_W-1:0]  den_reg;
    logic                       zero_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    skf_pkg::skf_qbit_t         q_out_reg;

    logic [REM_W-1:0] rem_sub;
    logic             rem_ge;
    logic             qbit;
    logic             last_step;

    // Compare, subtract and shift the partial remainder
    always_comb begin
        rem_sub   = rem_reg - {1'b0, den_reg};
        rem_ge    = rem_reg >= {1'b0, den_reg};
        qbit      = rem_ge & ~zero_reg;
        last_step = cnt_reg == CNT_W'(STEPS - 1);
        if (qbit) begin
            rem_next = {rem_sub[REM_W-2:0], 1'b0};
        end else begin
            rem_next = {rem_reg[REM_W-2:0], 1'b0};
        end
    end

    // Sequence control and quotient bit output
    always_ff @(posedge aclk) begin
        q_out_reg.qbit <= qbit;
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            cnt_reg         <= '0;
            q_out_reg.valid <= 1'b0;
            q_out_reg.last  <= 1'b0;
        end else begin
            q_out_reg.valid <= busy_reg;
            q_out_reg.last  <= busy_reg & last_step;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands, then advance one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, 1'b0, num};
            den_reg  <= den;
            zero_reg <= den == '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
        end
    end

    assign q_out = q_out_reg;

    `SKF_ASSERT_IMP(a_rem_bound, aclk, aresetn, busy_reg && !zero_reg, rem_reg < {den_reg, 1'b0})
    `SKF_ASSERT_NXT(a_last_ends, aclk, aresetn, q_out_reg.last, !q_out_reg.valid)

endmodule

@@ rtl/skf_mac.sv @@
// Serial accumulators that multiply gain by innovation and by predicted covariance.
`include "scalar_kalman_filter_assert.svh"
module skf_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  skf_pkg::skf_qbit_t                 bit_in,
    input  logic signed [skf_pkg::DIFF_W-1:0]  diff,
    input  logic [skf_pkg::DATA_W-1:0]         pm,
    input  logic signed [skf_pkg::DATA_W-1:0]  est,
    output logic                               done,
    output logic signed [skf_pkg::DATA_W-1:0]  est_new,
    output logic [skf_pkg::DATA_W-1:0]         cov_new,
    output logic [skf_pkg::GAIN_W-1:0]         gain
);

    localparam int AE_W = skf_pkg::GAIN_W + skf_pkg::DIFF_W + 1;
    localparam int AC_W = skf_pkg::GAIN_W + skf_pkg::DATA_W;
    localparam int CD_W = AC_W + 1 - skf_pkg::GAIN_BITS;

    logic signed [AE_W-1:0]      acc_e_reg, acc_e_next;
    logic [AC_W-1:0]             acc_c_reg, acc_c_next;
    logic [skf_pkg::GAIN_W-1:0]  gain_reg, gain_next;
    logic                        done_reg;

    logic signed [AE_W-1:0] est_sum;
    logic [AC_W:0]          cov_ceil_sum;
    logic [CD_W-1:0]        cov_dec;

    // Horner step: double and add the operand when the quotient bit is set
    always_comb begin
        acc_e_next = acc_e_reg <<< 1;
        acc_c_next = acc_c_reg << 1;
        if (bit_in.qbit) begin
            acc_e_next = acc_e_next + AE_W'(diff);
            acc_c_next = acc_c_next + AC_W'(pm);
        end
        gain_next = {gain_reg[skf_pkg::GAIN_W-2:0], bit_in.qbit};
    end

    // Done flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (start) begin
            done_reg <= 1'b0;
        end else if (bit_in.valid && bit_in.last) begin
            done_reg <= 1'b1;
        end
    end

    // Accumulators: clear on a new request, absorb each quotient bit
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_e_reg <= '0;
            acc_c_reg <= '0;
            gain_reg  <= '0;
        end else if (bit_in.valid) begin
            acc_e_reg <= acc_e_next;
            acc_c_reg <= acc_c_next;
            gain_reg  <= gain_next;
        end
    end

    // Floor the estimate step; covariance is pm minus the ceiling of gain*pm
    always_comb begin
        est_sum      = AE_W'(est) + (acc_e_reg >>> skf_pkg::GAIN_BITS);
        cov_ceil_sum = {1'b0, acc_c_reg} + (AC_W + 1)'(skf_pkg::GAIN_ONE - 1);
        cov_dec      = cov_ceil_sum[AC_W:skf_pkg::GAIN_BITS];
    end

    assign est_new = est_sum[skf_pkg::DATA_W-1:0];
    assign cov_new = pm - cov_dec[skf_pkg::DATA_W-1:0];
    assign gain    = gain_reg;
    assign done    = done_reg;

    `SKF_ASSERT_IMP(a_no_bit_after_done, aclk, aresetn, done_reg, !bit_in.valid)

endmodule

@@ rtl/scalar_kalman_filter.sv @@
// Top level of the scalar Kalman filter: handshakes, state, config and control.
// One-dimensional Kalman filter (unit transition and observation) in Q16.16
// fixed point. Each signed integer sample on the s_ channel runs one
// predict/update step and returns the new estimate and the Q0.16 gain used
// (65536 means one) on the m_ channel. Process and measurement noise are
// written through the cfg port (index 0 and 1, other indexes are ignored)
// and must only change while the filter is idle. On acceptance of a sample the
// predicted covariance and innovation are registered and the bit-serial gain
// divider starts, producing one quotient bit per cycle; the serial
// multiply-accumulate consumes those bits from the divider's output register,
// and the result is committed before the next sample can be accepted.
// The result sits in an output register, so a new sample is accepted while
// the previous result still waits to be taken.
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [skf_pkg::DATA_W-1:0]   m_estimate,
    output logic [skf_pkg::GAIN_W-1:0]          m_gain
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_BUSY = 1'b1;

    localparam int ZW = 16 + FRAC_BITS + 1;
    localparam int CW = (ZW > skf_pkg::DIFF_W) ? ZW : skf_pkg::DIFF_W;
    localparam logic signed [CW-1:0] Z_MAX = CW'(64'sd2147483647);
    localparam logic signed [CW-1:0] Z_MIN = CW'(-64'sd2147483648);

    logic [0:0]                          state_reg, state_next;
    logic [skf_pkg::DATA_W-1:0]          process_noise_reg;
    logic [skf_pkg::DATA_W-1:0]          measure_noise_reg;
    logic signed [skf_pkg::DATA_W-1:0]   est_value_reg;
    logic [skf_pkg::DATA_W-1:0]          err_cov_reg;
    logic [skf_pkg::DATA_W-1:0]          pm_reg;
    logic signed [skf_pkg::DIFF_W-1:0]   diff_reg;
    logic                                m_valid_reg;
    logic signed [skf_pkg::DATA_W-1:0]   m_estimate_reg;
    logic [skf_pkg::GAIN_W-1:0]          m_gain_reg;

    logic                                in_acc;
    logic                                commit;
    logic signed [CW-1:0]                sample_ext;
    logic signed [CW-1:0]                z_wide;
    logic signed [skf_pkg::DATA_W-1:0]   z_val;
    logic signed [skf_pkg::DIFF_W-1:0]   diff_val;
    logic [skf_pkg::DATA_W:0]            pm_sum;
    logic [skf_pkg::DATA_W-1:0]          pm_val;
    logic [skf_pkg::DEN_W-1:0]           den_val;

    skf_pkg::skf_qbit_t                  qbit;
    logic                                mac_done;
    logic signed [skf_pkg::DATA_W-1:0]   est_new;
    logic [skf_pkg::DATA_W-1:0]          cov_new;
    logic [skf_pkg::GAIN_W-1:0]          gain_val;

    // Handshake control
    assign s_ready = state_reg == ST_IDLE;
    assign in_acc  = s_valid && s_ready;
    assign commit  = (state_reg == ST_BUSY) && mac_done && (!m_valid_reg || m_ready);

    // Scale the sample and saturate to 32 bits
    always_comb begin
        sample_ext = CW'(s_sample);
        z_wide     = sample_ext <<< FRAC_BITS;
        if (z_wide > Z_MAX) begin
            z_val = Z_MAX[skf_pkg::DATA_W-1:0];
        end else if (z_wide < Z_MIN) begin
            z_val = Z_MIN[skf_pkg::DATA_W-1:0];
        end else begin
            z_val = z_wide[skf_pkg::DATA_W-1:0];
        end
        diff_val = {z_val[skf_pkg::DATA_W-1], z_val}
                 - {est_value_reg[skf_pkg::DATA_W-1], est_value_reg};
    end

    // Predict covariance with saturation and form the gain denominator
    always_comb begin
        pm_sum = {1'b0, err_cov_reg} + {1'b0, process_noise_reg};
        if (pm_sum[skf_pkg::DATA_W]) begin
            pm_val = '1;
        end else begin
            pm_val = pm_sum[skf_pkg::DATA_W-1:0];
        end
        den_val = {1'b0, pm_val} + {1'b0, measure_noise_reg};
    end

    // State machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, filter state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            est_value_reg     <= '0;
            err_cov_reg       <= '0;
            process_noise_reg <= skf_pkg::PROCESS_NOISE_RST;
            measure_noise_reg <= skf_pkg::MEASURE_NOISE_RST;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg   <= 1'b1;
                est_value_reg <= est_new;
                err_cov_reg   <= cov_new;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    skf_pkg::REG_PROCESS_NOISE: process_noise_reg <= cfg_wdata;
                    skf_pkg::REG_MEASURE_NOISE: measure_noise_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Hold operands for the accumulators and load the output register
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pm_reg   <= pm_val;
            diff_reg <= diff_val;
        end
        if (commit) begin
            m_estimate_reg <= est_new;
            m_gain_reg     <= gain_val;
        end
    end

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_acc),
        .num     (pm_val),
        .den     (den_val),
        .q_out   (qbit)
    );

    skf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_acc),
        .bit_in  (qbit),
        .diff    (diff_reg),
        .pm      (pm_reg),
        .est     (est_value_reg),
        .done    (mac_done),
        .est_new (est_new),
        .cov_new (cov_new),
        .gain    (gain_val)
    );

    assign m_valid    = m_valid_reg;
    assign m_estimate = m_estimate_reg;
    assign m_gain     = m_gain_reg;

    `SKF_ASSERT_NXT(a_accept_blocks, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SKF_ASSERT_IMP(a_gain_range, aclk, aresetn, m_valid, m_gain <= 17'h10000)

endmodule
